// File: rtl/gcb_pkg.sv
// Shared types, constants and elaboration-time helpers for the bearing block.
// Used by every module in rtl; depends on nothing else.
`timescale 1ns / 1ps

package gcb_pkg;

    // fixed-point format and CORDIC depth
    localparam int FRAC   = 30;
    localparam int ITERS  = 32;
    localparam int AW     = 34;          // rotation datapath and product width
    localparam int VW     = 36;          // vectoring datapath width
    localparam int SC_LAT  = ITERS + 2;  // sin/cos unit latency
    localparam int VEC_LAT = ITERS + 4;  // atan2 and conversion latency
    localparam int MUL_LAT = 5;          // product stages between the units
    localparam int RAD_LAT = 2;          // microdegree to radian stages

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NEAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TLAT = 2'd0;
    localparam logic [1:0] CFG_TLON = 2'd1;
    localparam logic [1:0] CFG_THR  = 2'd2;

    localparam int UDEG_90  = 90000000;
    localparam int UDEG_180 = 180000000;
    localparam int UDEG_360 = 360000000;

    localparam longint unsigned PI_Q60   = 64'h3243F6A8885A308D;
    localparam longint unsigned GAIN_DEC = 64'd607252935008881256;
    localparam longint unsigned DEC_ONE  = 64'd1000000000000000000;

    // floor(n * 2^sh / d), n < d < 2^63
    function automatic longint unsigned ratio_shift(longint unsigned n, int sh,
                                                    longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = n;
        for (int i = 0; i < sh; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // restoring long division, elaboration only
    function automatic longint unsigned long_div(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // atan(2^-i) in QFRAC: Q62 Taylor sum, rounded half up
    function automatic logic signed [VW-1:0] atan_entry(int i);
        longint unsigned q;
        longint unsigned term;
        int e;
        q = 64'd0;
        if (i == 0) begin
            q = PI_Q60;
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = i * (2 * k + 1);
                if (e <= 62) begin
                    term = long_div(64'd1 << (62 - e), longint'(2 * k + 1));
                    if ((k & 1) != 0) q = q - term;
                    else              q = q + term;
                end
            end
        end
        return VW'((q + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
    endfunction

    localparam longint unsigned PI_F_U = (PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
    localparam logic signed [VW-1:0] PI_F    = VW'(PI_F_U);
    localparam logic signed [AW-1:0] PI_F_A  = AW'(PI_F_U);
    localparam logic signed [AW-1:0] PI_HALF = AW'(PI_F_U >> 1);
    localparam logic signed [AW-1:0] GAIN    = AW'(ratio_shift(GAIN_DEC, FRAC, DEC_ONE));
    localparam logic [34:0] K60  = 35'(PI_Q60 / 64'd180000000);
    localparam logic [57:0] C32  = 58'(ratio_shift(64'd180000000, 92, PI_Q60));

    // magnitude of a product operand; CORDIC outputs stay well below 2^31
    function automatic logic [31:0] mag32(logic signed [AW-1:0] v);
        logic signed [AW-1:0] a;
        a = v[AW-1] ? -v : v;
        return a[31:0];
    endfunction

    // round a Q2F magnitude half up to QF and restore the sign
    function automatic logic signed [AW-1:0] round_q(logic [63:0] p, logic neg);
        logic [63:0] s;
        logic signed [AW-1:0] q;
        s = p + (64'd1 << (FRAC - 1));
        q = AW'(s >> FRAC);
        return neg ? -q : q;
    endfunction

    // one item between front and back
    typedef struct packed {
        logic signed [27:0] lat;
        logic signed [28:0] dlon;
        logic signed [27:0] tlat;
        logic [1:0]         status;
    } t_item;

endpackage

// File: rtl/gcb_front.sv
// Front end: range check, at-target check and longitude difference wrap.
// Depends on gcb_pkg.
`timescale 1ns / 1ps

module gcb_front (
    input  logic signed [27:0] i_lat,
    input  logic signed [28:0] i_lon,
    input  logic signed [27:0] i_tlat,
    input  logic signed [28:0] i_tlon,
    input  logic [19:0]        i_thr,
    output gcb_pkg::t_item     o_item
);

    logic signed [28:0] dlat;
    logic signed [29:0] dlonr;
    logic signed [29:0] dlonw;
    logic [28:0]        alat;
    logic [29:0]        alon;
    logic               out_range;
    logic               near;

    // raw differences for the at-target test, and the range check
    always_comb begin
        dlat  = 29'(i_lat) - 29'(i_tlat);
        dlonr = 30'(i_tlon) - 30'(i_lon);
        alat  = dlat[28] ? 29'(-dlat) : 29'(dlat);
        alon  = dlonr[29] ? 30'(-dlonr) : 30'(dlonr);
        near  = (alat < 29'(i_thr)) && (alon < 30'(i_thr));
        out_range = (i_lat > gcb_pkg::UDEG_90) || (i_lat < -gcb_pkg::UDEG_90) ||
                    (i_lon > gcb_pkg::UDEG_180) || (i_lon < -gcb_pkg::UDEG_180);
    end

    // wrap the longitude difference into one turn
    always_comb begin
        if (dlonr > gcb_pkg::UDEG_180) begin
            dlonw = 30'(dlonr - 30'(gcb_pkg::UDEG_360));
        end else if (dlonr < -gcb_pkg::UDEG_180) begin
            dlonw = 30'(dlonr + 30'(gcb_pkg::UDEG_360));
        end else begin
            dlonw = dlonr;
        end
    end

    always_comb begin
        o_item.lat  = i_lat;
        o_item.dlon = dlonw[28:0];
        o_item.tlat = i_tlat;
        if (out_range)  o_item.status = gcb_pkg::ST_RANGE;
        else if (near)  o_item.status = gcb_pkg::ST_NEAR;
        else            o_item.status = gcb_pkg::ST_OK;
    end

endmodule

// File: rtl/gcb_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on gcb_pkg.
`timescale 1ns / 1ps

module gcb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gcb_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_avail,
    output gcb_pkg::t_item o_item
);

    gcb_pkg::t_item r_mem [0:1];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_avail)) n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop && o_avail) n_cnt = r_cnt - 2'd1;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop && o_avail) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// File: rtl/gcb_sincos.sv
// Pipelined rotation CORDIC: sine and cosine of a QFRAC angle, one per cycle.
// Depends on gcb_pkg.
`timescale 1ns / 1ps

module gcb_sincos (
    input  logic                             i_clk,
    input  logic signed [gcb_pkg::AW-1:0]    i_ang,
    output logic signed [gcb_pkg::AW-1:0]    o_sin,
    output logic signed [gcb_pkg::AW-1:0]    o_cos
);

    localparam int AW = gcb_pkg::AW;
    localparam int N  = gcb_pkg::ITERS;

    logic signed [AW-1:0] r_x [0:N];
    logic signed [AW-1:0] r_y [0:N];
    logic signed [AW-1:0] r_z [0:N];
    logic                 r_neg [0:N];

    // fold into the right half plane, results negated later
    always_ff @(posedge i_clk) begin
        r_x[0] <= gcb_pkg::GAIN;
        r_y[0] <= '0;
        if (i_ang > gcb_pkg::PI_HALF) begin
            r_z[0]   <= i_ang - gcb_pkg::PI_F_A;
            r_neg[0] <= 1'b1;
        end else if (i_ang < -gcb_pkg::PI_HALF) begin
            r_z[0]   <= i_ang + gcb_pkg::PI_F_A;
            r_neg[0] <= 1'b1;
        end else begin
            r_z[0]   <= i_ang;
            r_neg[0] <= 1'b0;
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic signed [AW-1:0] ATAN = AW'(gcb_pkg::atan_entry(k));
        always_ff @(posedge i_clk) begin
            r_neg[k+1] <= r_neg[k];
            if (r_z[k] >= 0) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ATAN;
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ATAN;
            end
        end
    end

    // output register with the fold undone
    always_ff @(posedge i_clk) begin
        o_sin <= r_neg[N] ? -r_y[N] : r_y[N];
        o_cos <= r_neg[N] ? -r_x[N] : r_x[N];
    end

endmodule

// File: rtl/gcb_vector.sv
// Pipelined vectoring CORDIC for atan2, then radians to microdegrees.
// Depends on gcb_pkg.
`timescale 1ns / 1ps

module gcb_vector (
    input  logic                          i_clk,
    input  logic signed [gcb_pkg::VW-1:0] i_x,
    input  logic signed [gcb_pkg::VW-1:0] i_y,
    output logic signed [28:0]            o_bearing
);

    localparam int VW = gcb_pkg::VW;
    localparam int N  = gcb_pkg::ITERS;
    localparam logic [28:0] C_HI = gcb_pkg::C32[57:29];
    localparam logic [28:0] C_LO = gcb_pkg::C32[28:0];

    logic signed [VW-1:0] r_x [0:N];
    logic signed [VW-1:0] r_y [0:N];
    logic signed [VW-1:0] r_z [0:N];
    logic                 r_zero [0:N];

    logic [34:0] r_mag;
    logic        r_negz;
    logic        r_zero1;
    logic [63:0] r_ph;
    logic [63:0] r_pl;
    logic        r_negz2;
    logic        r_zero2;
    logic [92:0] sum;
    logic [30:0] q;
    logic [30:0] qc;

    // left half plane: flip the vector and start from plus or minus pi
    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_x == 0) && (i_y == 0);
        if (i_x < 0) begin
            r_z[0] <= (i_y >= 0) ? gcb_pkg::PI_F : -gcb_pkg::PI_F;
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
        end else begin
            r_z[0] <= '0;
            r_x[0] <= i_x;
            r_y[0] <= i_y;
        end
    end

    // drive y towards zero, one step per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic signed [VW-1:0] ATAN = gcb_pkg::atan_entry(k);
        always_ff @(posedge i_clk) begin
            r_zero[k+1] <= r_zero[k];
            if (r_y[k] > 0) begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ATAN;
            end else begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ATAN;
            end
        end
    end

    // magnitude, then split product against the degree scale
    always_ff @(posedge i_clk) begin
        r_mag   <= r_z[N][VW-1] ? 35'(-r_z[N]) : 35'(r_z[N]);
        r_negz  <= r_z[N][VW-1];
        r_zero1 <= r_zero[N];
        r_ph    <= 64'(r_mag) * 64'(C_HI);
        r_pl    <= 64'(r_mag) * 64'(C_LO);
        r_negz2 <= r_negz;
        r_zero2 <= r_zero1;
    end

    // recombine, round half up, clamp to half a turn
    always_comb begin
        sum = {r_ph[63:0], 29'd0} + 93'(r_pl) + (93'd1 << 61);
        q   = sum[92:62];
        qc  = (q > 31'(gcb_pkg::UDEG_180)) ? 31'(gcb_pkg::UDEG_180) : q;
    end

    always_ff @(posedge i_clk) begin
        if (r_zero2)      o_bearing <= '0;
        else if (r_negz2) o_bearing <= -$signed(qc[28:0]);
        else              o_bearing <= $signed(qc[28:0]);
    end

endmodule

// File: rtl/gcb_back.sv
// Back end: radians, three sin/cos units, bearing products and atan2.
// Depends on gcb_pkg, gcb_sincos and gcb_vector.
`timescale 1ns / 1ps

module gcb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gcb_pkg::t_item i_item,
    output logic           o_valid,
    output logic signed [28:0] o_bearing,
    output logic [1:0]     o_status
);

    localparam int AW = gcb_pkg::AW;
    localparam int VW = gcb_pkg::VW;
    localparam int D  = gcb_pkg::RAD_LAT + gcb_pkg::SC_LAT + gcb_pkg::MUL_LAT +
                        gcb_pkg::VEC_LAT;

    // sideband delay line
    logic [D-1:0] r_vd;
    logic [1:0]   r_sd [0:D-1];

    // radian conversion
    logic [28:0]          ua;
    logic [28:0]          ub;
    logic [28:0]          ud;
    logic [63:0]          r_pa;
    logic [63:0]          r_pb;
    logic [63:0]          r_pd;
    logic [2:0]           r_sg;
    logic signed [AW-1:0] r_aa;
    logic signed [AW-1:0] r_ab;
    logic signed [AW-1:0] r_ad;

    logic signed [AW-1:0] sa;
    logic signed [AW-1:0] ca;
    logic signed [AW-1:0] sb;
    logic signed [AW-1:0] cb;
    logic signed [AW-1:0] sd;
    logic signed [AW-1:0] cd;

    // product stages
    logic [63:0]          r_p1;
    logic [63:0]          r_p2;
    logic [63:0]          r_p3;
    logic [2:0]           r_ps;
    logic signed [AW-1:0] r_cd1;
    logic signed [AW-1:0] r_m1;
    logic signed [AW-1:0] r_m2;
    logic signed [AW-1:0] r_m3;
    logic signed [AW-1:0] r_cd2;
    logic [63:0]          r_p4;
    logic                 r_s4;
    logic signed [AW-1:0] r_m1b;
    logic signed [AW-1:0] r_m2b;
    logic signed [AW-1:0] r_m4;
    logic signed [AW-1:0] r_m1c;
    logic signed [AW-1:0] r_m2c;
    logic signed [VW-1:0] r_xv;
    logic signed [VW-1:0] r_yv;

    logic signed [28:0]   vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= '0;
        else          r_vd <= {r_vd[D-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= i_item.status;
    end

    for (genvar k = 1; k < D; k++) begin : g_sd
        always_ff @(posedge i_clk) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // microdegrees to radians: scale the magnitude, then round and sign
    always_comb begin
        ua = i_item.lat[27]  ? 29'(-30'(i_item.lat))  : 29'(i_item.lat);
        ub = i_item.tlat[27] ? 29'(-30'(i_item.tlat)) : 29'(i_item.tlat);
        ud = i_item.dlon[28] ? 29'(-30'(i_item.dlon)) : 29'(i_item.dlon);
    end

    always_ff @(posedge i_clk) begin
        r_pa <= 64'(ua) * 64'(gcb_pkg::K60);
        r_pb <= 64'(ub) * 64'(gcb_pkg::K60);
        r_pd <= 64'(ud) * 64'(gcb_pkg::K60);
        r_sg <= {i_item.dlon[28], i_item.tlat[27], i_item.lat[27]};
        r_aa <= gcb_pkg::round_q(r_pa, r_sg[0]);
        r_ab <= gcb_pkg::round_q(r_pb, r_sg[1]);
        r_ad <= gcb_pkg::round_q(r_pd, r_sg[2]);
    end

    gcb_sincos u_sc_a (.i_clk(i_clk), .i_ang(r_aa), .o_sin(sa), .o_cos(ca));
    gcb_sincos u_sc_b (.i_clk(i_clk), .i_ang(r_ab), .o_sin(sb), .o_cos(cb));
    gcb_sincos u_sc_d (.i_clk(i_clk), .i_ang(r_ad), .o_sin(sd), .o_cos(cd));

    // y = sin dlon cos latB, x = cos latA sin latB - sin latA cos latB cos dlon
    always_ff @(posedge i_clk) begin
        r_p1  <= 64'(gcb_pkg::mag32(sd)) * 64'(gcb_pkg::mag32(cb));
        r_p2  <= 64'(gcb_pkg::mag32(ca)) * 64'(gcb_pkg::mag32(sb));
        r_p3  <= 64'(gcb_pkg::mag32(sa)) * 64'(gcb_pkg::mag32(cb));
        r_ps  <= {sa[AW-1] ^ cb[AW-1], ca[AW-1] ^ sb[AW-1], sd[AW-1] ^ cb[AW-1]};
        r_cd1 <= cd;

        r_m1  <= gcb_pkg::round_q(r_p1, r_ps[0]);
        r_m2  <= gcb_pkg::round_q(r_p2, r_ps[1]);
        r_m3  <= gcb_pkg::round_q(r_p3, r_ps[2]);
        r_cd2 <= r_cd1;

        r_p4  <= 64'(gcb_pkg::mag32(r_m3)) * 64'(gcb_pkg::mag32(r_cd2));
        r_s4  <= r_m3[AW-1] ^ r_cd2[AW-1];
        r_m1b <= r_m1;
        r_m2b <= r_m2;

        r_m4  <= gcb_pkg::round_q(r_p4, r_s4);
        r_m1c <= r_m1b;
        r_m2c <= r_m2b;

        r_xv  <= VW'(r_m2c) - VW'(r_m4);
        r_yv  <= VW'(r_m1c);
    end

    gcb_vector u_vec (.i_clk(i_clk), .i_x(r_xv), .i_y(r_yv), .o_bearing(vb));

    assign o_valid   = r_vd[D-1];
    assign o_status  = r_sd[D-1];
    assign o_bearing = (r_sd[D-1] == gcb_pkg::ST_OK) ? vb : '0;

endmodule

// File: rtl/great_circle_bearing.sv
// Initial great-circle bearing toward a configured target, top level.
// Depends on gcb_pkg, gcb_front, gcb_queue and gcb_back.
//
// One request can be accepted every clock cycle. Each result appears on
// o_bearing and o_status for a single cycle, marked by o_valid; the delay after
// the request is set by the radian stages, the two 32-stage CORDIC pipelines
// (rotation for sine/cosine, vectoring for atan2) and the product stages between
// them. Results leave in request order and there is no way to hold them off, so
// the receiver must take o_valid as it comes. busy is high during reset; after
// that it only rises if the two-entry queue between the front and back ends is
// full, which the back end's one-per-cycle drain keeps from happening. Write the
// target registers only while no request is in flight.
`timescale 1ns / 1ps

module great_circle_bearing (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [27:0] i_observer_latitude,
    input  logic signed [28:0] i_observer_longitude,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [28:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [28:0] o_bearing,
    output logic [1:0]         o_status
);

    logic signed [27:0] r_tlat;
    logic signed [28:0] r_tlon;
    logic [19:0]        r_thr;

    gcb_pkg::t_item front_item;
    gcb_pkg::t_item head_item;
    logic           push;
    logic           full;
    logic           avail;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlat <= 28'sd21422495;
            r_tlon <= 29'sd39826165;
            r_thr  <= 20'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcb_pkg::CFG_TLAT: r_tlat <= i_cfg_data[27:0];
                gcb_pkg::CFG_TLON: r_tlon <= i_cfg_data[28:0];
                gcb_pkg::CFG_THR:  r_thr  <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign busy = full || !i_rst_n;
    assign push = start && !busy;

    gcb_front u_front (
        .i_lat  (i_observer_latitude),
        .i_lon  (i_observer_longitude),
        .i_tlat (r_tlat),
        .i_tlon (r_tlon),
        .i_thr  (r_thr),
        .o_item (front_item)
    );

    gcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (avail),
        .o_full  (full),
        .o_avail (avail),
        .o_item  (head_item)
    );

    gcb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (avail),
        .i_item    (head_item),
        .o_valid   (o_valid),
        .o_bearing (o_bearing),
        .o_status  (o_status)
    );

endmodule

// File: tb/tb_great_circle_bearing.sv
// Self-checking bench for great_circle_bearing: random and directed observer positions
// against an in-bench fixed-point bearing predictor. Depends on gcb_pkg and the rtl.
`timescale 1ns / 1ps

module tb_great_circle_bearing;
    import gcb_pkg::*;

    typedef enum logic [1:0] {E_REQ, E_CFG, E_DRAIN} t_kind;

    typedef struct {
        t_kind              kind;
        logic signed [27:0] lat;
        logic signed [28:0] lon;
        logic [1:0]         idx;
        logic [28:0]        data;
        int                 idle_pct;
    } t_entry;

    typedef struct {
        logic signed [28:0] bearing;
        logic [1:0]         status;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [27:0] i_observer_latitude = '0;
    logic signed [28:0] i_observer_longitude = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_TLAT;
    logic [28:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [28:0] o_bearing;
    logic [1:0]         o_status;

    great_circle_bearing dut (.*);

    always #10 i_clk = ~i_clk;

    // target registers as the bench believes them
    logic signed [27:0] tgt_lat = 28'sd21422495;
    logic signed [28:0] tgt_lon = 29'sd39826165;
    logic [19:0]        near_thr = 20'd10000;

    // fixed-point tables
    longint          atan_q[ITERS];
    longint          pi_q, gain_q;
    longint unsigned k60, c32;

    t_entry  pending[$];
    t_result bearing_due[$];
    logic    req_taken = 1'b0;
    int      quiet = 0;
    int      stall = 0;
    int      errors = 0;

    function automatic longint unsigned absv(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // QF product, rounded half away from zero
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        longint r;
        p = {64'd0, absv(a)} * {64'd0, absv(b)};
        r = longint'((p + (128'd1 << (FRAC - 1))) >> FRAC);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint to_rad(longint u);
        logic [127:0] p;
        longint r;
        p = {64'd0, absv(u)} * {64'd0, k60};
        r = longint'((p + (128'd1 << (60 - FRAC - 1))) >> (60 - FRAC));
        return u < 0 ? -r : r;
    endfunction

    // rotation CORDIC, fold beyond a right angle
    task automatic rotate(input longint ang, output longint sn, output longint cs);
        longint x, y, z, dx, dy;
        logic neg;
        neg = 1'b0;
        if (ang > pi_q / 2) begin
            ang = ang - pi_q;
            neg = 1'b1;
        end else if (ang < -(pi_q / 2)) begin
            ang = ang + pi_q;
            neg = 1'b1;
        end
        x = gain_q;
        y = 0;
        z = ang;
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_q[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_q[i];
            end
        end
        sn = neg ? -y : y;
        cs = neg ? -x : x;
    endtask

    task automatic predict_bearing(input logic signed [27:0] lat_in,
                                   input logic signed [28:0] lon_in,
                                   output t_result res);
        longint a, b, tl, tn, dl, sa, ca, sb, cb, sd, cd, xv, yv, zv, dx, dy;
        longint unsigned m;
        logic [127:0] p;
        a = lat_in; b = lon_in; tl = tgt_lat; tn = tgt_lon;
        res.bearing = '0;
        res.status = ST_OK;
        if (a > UDEG_90 || a < -UDEG_90 || b > UDEG_180 || b < -UDEG_180) begin
            res.status = ST_RANGE;
            return;
        end
        if (absv(a - tl) < near_thr && absv(b - tn) < near_thr) begin
            res.status = ST_NEAR;
            return;
        end
        dl = tn - b;
        repeat (2) begin
            if (dl > UDEG_180) dl = dl - UDEG_360;
            else if (dl < -UDEG_180) dl = dl + UDEG_360;
        end
        rotate(to_rad(a), sa, ca);
        rotate(to_rad(tl), sb, cb);
        rotate(to_rad(dl), sd, cd);
        yv = fx_mul(sd, cb);
        xv = fx_mul(ca, sb) - fx_mul(fx_mul(sa, cb), cd);
        if (xv == 0 && yv == 0) return;
        // vectoring CORDIC, left half-plane folded first
        zv = 0;
        if (xv < 0) begin
            zv = (yv >= 0) ? pi_q : -pi_q;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv = xv + dx; yv = yv - dy; zv = zv + atan_q[i];
            end else begin
                xv = xv - dx; yv = yv + dy; zv = zv - atan_q[i];
            end
        end
        p = {64'd0, absv(zv)} * {64'd0, c32};
        m = longint'((p + (128'd1 << (FRAC + 31))) >> (FRAC + 32));
        if (m > UDEG_180) m = UDEG_180;
        res.bearing = zv < 0 ? -29'(m) : 29'(m);
    endtask

    // driver: one assignment per signal per falling edge
    always @(negedge i_clk) begin
        logic   nstart;
        logic   nwe;
        t_entry e;
        nstart = 1'b0;
        nwe = 1'b0;
        if (req_taken && pending.size() > 0) void'(pending.pop_front());
        if (start && !req_taken) begin
            nstart = 1'b1;
        end else if (i_rst_n && pending.size() > 0) begin
            e = pending[0];
            case (e.kind)
                E_REQ: begin
                    if ($urandom_range(99) >= e.idle_pct) begin
                        nstart = 1'b1;
                        i_observer_latitude <= e.lat;
                        i_observer_longitude <= e.lon;
                    end
                end
                E_CFG: begin
                    if (bearing_due.size() == 0 && quiet >= 90) begin
                        nwe = 1'b1;
                        i_cfg_idx <= e.idx;
                        i_cfg_data <= e.data;
                        case (e.idx)
                            CFG_TLAT: tgt_lat = e.data[27:0];
                            CFG_TLON: tgt_lon = e.data[28:0];
                            default:  near_thr = e.data[19:0];
                        endcase
                        void'(pending.pop_front());
                    end
                end
                default: begin
                    if (bearing_due.size() == 0) void'(pending.pop_front());
                end
            endcase
        end
        start <= nstart;
        i_cfg_we <= nwe;
    end

    // monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        t_result want;
        logic    took;
        took = i_rst_n && start && !busy;
        req_taken <= took;
        if (took) begin
            predict_bearing(i_observer_latitude, i_observer_longitude, want);
            bearing_due.push_back(want);
        end
        if (i_rst_n && o_valid) begin
            if (bearing_due.size() == 0) begin
                $display("%0t: unexpected result bearing %0d status %0d",
                         $time, o_bearing, o_status);
                errors++;
            end else begin
                want = bearing_due.pop_front();
                if (o_bearing !== want.bearing) begin
                    $display("%0t: bearing expected %0d actual %0d",
                             $time, want.bearing, o_bearing);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
            end
        end
        quiet <= (took || o_valid || bearing_due.size() != 0) ? 0 : quiet + 1;
        stall <= (took || o_valid) ? 0 : stall + 1;
        if (stall > 3000) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_req(input longint la, input longint lo, input int idle);
        t_entry e;
        e.kind = E_REQ; e.lat = 28'(la); e.lon = 29'(lo); e.idx = CFG_TLAT;
        e.data = '0; e.idle_pct = idle;
        pending.push_back(e);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input longint val);
        t_entry e;
        e.kind = E_CFG; e.lat = '0; e.lon = '0; e.idx = idx; e.data = 29'(val);
        e.idle_pct = 0;
        pending.push_back(e);
    endtask

    task automatic add_drain();
        t_entry e;
        e.kind = E_DRAIN; e.lat = '0; e.lon = '0; e.idx = CFG_TLAT; e.data = '0;
        e.idle_pct = 0;
        pending.push_back(e);
    endtask

    // random observer: mostly valid, some near the target, some raw full width
    task automatic add_random(input longint tla, input longint tlo, input longint thr,
                              input int idle);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            add_req(longint'($urandom_range(180000000)) - 90000000,
                    longint'($urandom_range(360000000)) - 180000000, idle);
        else if (sel < 85)
            add_req(tla + longint'($urandom_range(2 * thr + 4)) - thr - 2,
                    tlo + longint'($urandom_range(2 * thr + 4)) - thr - 2, idle);
        else
            add_req(longint'($signed(28'($urandom))), longint'($signed(29'($urandom))), idle);
    endtask

    initial begin
        logic [127:0] w;
        longint unsigned q, term;
        int e, idle;
        longint tla, tlo, thr;
        // tables
        for (int i = 0; i < ITERS; i++) begin
            q = 0;
            if (i == 0) q = PI_Q60;
            else for (int k = 0; k < 32; k++) begin
                e = i * (2 * k + 1);
                if (e <= 62) begin
                    term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
                    q = (k % 2) ? q - term : q + term;
                end
            end
            atan_q[i] = longint'((q + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
        end
        pi_q = longint'((PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
        w = ({64'd0, GAIN_DEC} << FRAC) / {64'd0, DEC_ONE};
        gain_q = longint'(w);
        k60 = PI_Q60 / 64'd180000000;
        w = (128'd180000000 << 92) / {64'd0, PI_Q60};
        c32 = w[63:0];

        // directed: field extremes, range bounds, at target, wrap, poles
        add_req(90000000, 180000000, 0);
        add_req(-90000000, -180000000, 0);
        add_req(90000001, 0, 0);
        add_req(-90000001, 0, 0);
        add_req(0, 180000001, 0);
        add_req(0, -180000001, 0);
        add_req(-134217728, -268435456, 0);
        add_req(134217727, 268435455, 0);
        add_req(21422495, 39826165, 0);
        add_req(21422495 + 9999, 39826165 - 9999, 0);
        add_req(21422495 + 10000, 39826165, 0);
        add_req(0, -180000000, 0);
        add_req(-21422495, -140173835, 0);
        add_req(0, 0, 0);
        add_cfg(CFG_THR, 0);
        add_cfg(CFG_TLAT, 90000000);
        add_cfg(CFG_TLON, -180000000);
        add_req(90000000, 0, 0);
        add_req(90000000, -180000000, 0);
        add_req(-90000000, 179000000, 0);
        add_req(45000000, 170000000, 0);
        add_cfg(CFG_TLAT, -134217728);
        add_cfg(CFG_TLON, 268435455);
        add_cfg(CFG_THR, 1048575);
        add_req(10000000, 10000000, 0);
        add_req(-89000000, -179000000, 0);
        add_drain();

        // random phases, configuration changed while idle
        for (int ph = 0; ph < 6; ph++) begin
            idle = (ph < 2) ? 31 : (ph < 4) ? 56 : 0;
            case (ph)
                0: begin tla = -90000000; tlo = 180000000; thr = 1000000; end
                1: begin tla = 0; tlo = 0; thr = 1; end
                default: begin
                    tla = longint'($urandom_range(180000000)) - 90000000;
                    tlo = longint'($urandom_range(360000000)) - 180000000;
                    thr = $urandom_range(200000);
                end
            endcase
            add_cfg(CFG_TLAT, tla);
            add_cfg(CFG_TLON, tlo);
            add_cfg(CFG_THR, thr);
            for (int n = 0; n < 125; n++) begin
                add_random(tla, tlo, thr, (n % 40 < 10) ? 0 : idle);
                if (n == 60) add_drain();
            end
        end

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        while (pending.size() != 0 || bearing_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && bearing_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: great_circle_bearing.f
rtl/gcb_pkg.sv
rtl/gcb_front.sv
rtl/gcb_queue.sv
rtl/gcb_sincos.sv
rtl/gcb_vector.sv
rtl/gcb_back.sv
rtl/great_circle_bearing.sv
tb/tb_great_circle_bearing.sv
